// ===== src/dvtu_pkg.sv =====
// constants, types and a helper function shared by the routing table update block
`default_nettype none
package dvtu_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ADDR_W      = 32;
   localparam int COST_W      = 8;
   localparam int ACT_W       = 3;
   localparam int OUT_IDX_W   = 6;
   localparam int OUT_CNT_W   = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int OWN_NUM     = 4;
   localparam int OWN_CNT_W   = 3;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_IFACE_0   = 3'd0,
      CSR_OWN_IFACE_1   = 3'd1,
      CSR_OWN_IFACE_2   = 3'd2,
      CSR_OWN_IFACE_3   = 3'd3,
      CSR_OWN_IFACE_CNT = 3'd4
   } csr_index_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_IGNORED   = 3'd0,
      ACT_UNCHANGED = 3'd1,
      ACT_IMPROVED  = 3'd2,
      ACT_INSERTED  = 3'd3,
      ACT_DROPPED   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] dest;
      logic [COST_W-1:0] cost;
      logic [ADDR_W-1:0] next_hop;
      logic [ADDR_W-1:0] iface;
   } route_entry_type;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] dest;
      logic [COST_W-1:0] cost;
      logic [ADDR_W-1:0] next_hop;
      logic [ADDR_W-1:0] iface;
      logic              own_hit;
   } item_type;

   typedef struct packed {
      action_type           action;
      logic [OUT_IDX_W-1:0] entry_index;
      logic [COST_W-1:0]    entry_cost;
      logic [ADDR_W-1:0]    entry_next_hop;
      logic [ADDR_W-1:0]    entry_iface;
      logic [OUT_CNT_W-1:0] table_count;
   } result_type;

   // advertised cost plus one hop, saturating
   function automatic logic [COST_W-1:0] cost_inc(input logic [COST_W-1:0] cost);
      logic [COST_W-1:0] res;
      res = (cost == COST_MAX) ? COST_MAX : cost + COST_W'(1);
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== src/dvtu_if.sv =====
// request, response and register write channel interfaces
`default_nettype none
interface dvtu_req_if;
   import dvtu_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [ADDR_W-1:0] dest_addr;
   logic [COST_W-1:0] adv_cost;
   logic [ADDR_W-1:0] adv_next_hop;
   logic [ADDR_W-1:0] sender_addr;
   logic [ADDR_W-1:0] arrival_iface;

   modport source (output valid, mode, dest_addr, adv_cost, adv_next_hop, sender_addr,
                   arrival_iface, input ready);
   modport sink   (input valid, mode, dest_addr, adv_cost, adv_next_hop, sender_addr,
                   arrival_iface, output ready);
endinterface

interface dvtu_rsp_if;
   import dvtu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ACT_W-1:0]     action;
   logic [OUT_IDX_W-1:0] entry_index;
   logic [COST_W-1:0]    entry_cost;
   logic [ADDR_W-1:0]    entry_next_hop;
   logic [ADDR_W-1:0]    entry_iface;
   logic [OUT_CNT_W-1:0] table_count;

   modport source (output valid, action, entry_index, entry_cost, entry_next_hop,
                   entry_iface, table_count, input ready);
   modport sink   (input valid, action, entry_index, entry_cost, entry_next_hop,
                   entry_iface, table_count, output ready);
endinterface

interface dvtu_csr_if;
   import dvtu_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/dvtu_route_ram.sv =====
// route table memory, one write port and one registered read port
`default_nettype none
module dvtu_route_ram (
   input  wire                               clock,
   input  wire                               wr_en,
   input  wire  [dvtu_pkg::IDX_W-1:0]        wr_addr,
   input  dvtu_pkg::route_entry_type         wr_data,
   input  wire  [dvtu_pkg::IDX_W-1:0]        rd_addr,
   output dvtu_pkg::route_entry_type         rd_data
);
   import dvtu_pkg::*;

   route_entry_type mem [TABLE_DEPTH];
   route_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/distance_vector_table_update.sv =====
// top level of the distance vector routing table update block
//
// req: one transaction per route, either a local route to load (mode 0) or one
// entry of a neighbour's advertisement (mode 1). rsp: exactly one transaction per
// request, carrying the action taken, the slot concerned, its contents after the
// update and the number of routes held. csr: writes of the own interface
// addresses and their count, always ready; write only while the block is idle.
//
// The table sits in a single-port-read memory with a registered read port.
// An advertised route is compared against the stored routes one slot per cycle,
// up to the table fill count (at most TABLE_DEPTH slots); a local load takes no
// search. The search stops early on an ignored or improved route.
// One request is in work at a time; a finished result sits in the rsp output
// register, so the next request is taken while rsp is stalled, and that request
// waits at its end until the register is free.
//
// Reset empties the table (fill count zero) and clears the csr registers; the
// memory itself is not cleared, since only the contents of filled slots are ever used.
`default_nettype none
module distance_vector_table_update (
   input  wire        clock,
   input  wire        reset,
   dvtu_req_if.sink   req_if,
   dvtu_rsp_if.source rsp_if,
   dvtu_csr_if.sink   csr_if
);
   import dvtu_pkg::*;

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     first_idx_ff, first_idx_in;
   route_entry_type      first_ent_ff, first_ent_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   result_type           res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   logic [ADDR_W-1:0]    own_iface_ff [OWN_NUM];
   logic [OWN_CNT_W-1:0] own_count_ff;

   logic                 req_take;
   logic                 csr_take;
   logic                 out_free;
   logic                 own_hit;
   logic                 issue;
   logic                 match;
   logic                 ignore_hit;
   logic                 improve_hit;
   logic                 found_now;
   logic                 done;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   route_entry_type      wr_data;
   route_entry_type      rd_data;
   route_entry_type      item_ent;

   dvtu_route_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_take      = req_if.valid && req_if.ready;
   assign csr_take      = csr_if.valid && csr_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OWN_NUM; i++) begin
            own_iface_ff[i] <= '0;
         end
         own_count_ff <= '0;
      end else if (csr_take) begin
         case (csr_if.index)
            CSR_OWN_IFACE_0:   own_iface_ff[0] <= csr_if.data;
            CSR_OWN_IFACE_1:   own_iface_ff[1] <= csr_if.data;
            CSR_OWN_IFACE_2:   own_iface_ff[2] <= csr_if.data;
            CSR_OWN_IFACE_3:   own_iface_ff[3] <= csr_if.data;
            CSR_OWN_IFACE_CNT: own_count_ff    <= csr_if.data[OWN_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // advertised next hop is one of our own interfaces
   always_comb begin
      own_hit = 1'b0;
      for (int i = 0; i < OWN_NUM; i++) begin
         if ((own_count_ff > OWN_CNT_W'(i)) && (own_iface_ff[i] == req_if.adv_next_hop)) begin
            own_hit = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_SCAN;
         ST_SCAN: if (done)     state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // search, update and result
   always_comb begin
      item_in      = item_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      found_in     = found_ff;
      first_idx_in = first_idx_ff;
      first_ent_in = first_ent_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff;
      done         = 1'b0;

      item_ent.dest     = item_ff.dest;
      item_ent.cost     = item_ff.cost;
      item_ent.next_hop = item_ff.next_hop;
      item_ent.iface    = item_ff.iface;
      wr_data           = item_ent;

      issue       = item_ff.mode && (rd_idx_ff < count_ff);
      match       = pend_ff && (rd_data.dest == item_ff.dest);
      ignore_hit  = match && !found_ff && item_ff.own_hit;
      improve_hit = match && !ignore_hit && (rd_data.cost > item_ff.cost);
      found_now   = found_ff || match;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in.mode     = req_if.mode;
               item_in.dest     = req_if.dest_addr;
               item_in.cost     = req_if.mode ? cost_inc(req_if.adv_cost) : req_if.adv_cost;
               item_in.next_hop = req_if.mode ? req_if.sender_addr : req_if.adv_next_hop;
               item_in.iface    = req_if.arrival_iface;
               item_in.own_hit  = own_hit;
               rd_idx_in        = '0;
               found_in         = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end
            if (match && !found_ff) begin
               found_in     = 1'b1;
               first_idx_in = pend_idx_ff;
               first_ent_in = rd_data;
            end
            res_in.table_count = OUT_CNT_W'(count_ff);
            if (ignore_hit) begin
               done                  = 1'b1;
               res_in.action         = ACT_IGNORED;
               res_in.entry_index    = OUT_IDX_W'(pend_idx_ff);
               res_in.entry_cost     = rd_data.cost;
               res_in.entry_next_hop = rd_data.next_hop;
               res_in.entry_iface    = rd_data.iface;
            end else if (improve_hit) begin
               done                  = 1'b1;
               wr_en                 = 1'b1;
               wr_addr               = pend_idx_ff;
               wr_data.dest          = rd_data.dest;
               res_in.action         = ACT_IMPROVED;
               res_in.entry_index    = OUT_IDX_W'(pend_idx_ff);
               res_in.entry_cost     = item_ff.cost;
               res_in.entry_next_hop = item_ff.next_hop;
               res_in.entry_iface    = item_ff.iface;
            end else if (!issue) begin
               done = 1'b1;
               if (found_now) begin
                  res_in.action         = ACT_UNCHANGED;
                  if (found_ff) begin
                     res_in.entry_index    = OUT_IDX_W'(first_idx_ff);
                     res_in.entry_cost     = first_ent_ff.cost;
                     res_in.entry_next_hop = first_ent_ff.next_hop;
                     res_in.entry_iface    = first_ent_ff.iface;
                  end else begin
                     res_in.entry_index    = OUT_IDX_W'(pend_idx_ff);
                     res_in.entry_cost     = rd_data.cost;
                     res_in.entry_next_hop = rd_data.next_hop;
                     res_in.entry_iface    = rd_data.iface;
                  end
               end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  wr_en                 = 1'b1;
                  wr_addr               = count_ff[IDX_W-1:0];
                  count_in              = count_ff + CNT_W'(1);
                  res_in.action         = ACT_INSERTED;
                  res_in.entry_index    = OUT_IDX_W'(count_ff);
                  res_in.entry_cost     = item_ff.cost;
                  res_in.entry_next_hop = item_ff.next_hop;
                  res_in.entry_iface    = item_ff.iface;
                  res_in.table_count    = OUT_CNT_W'(count_ff + CNT_W'(1));
               end else begin
                  res_in.action         = ACT_DROPPED;
                  res_in.entry_index    = '0;
                  res_in.entry_cost     = '0;
                  res_in.entry_next_hop = '0;
                  res_in.entry_iface    = '0;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      pend_idx_ff  <= rd_idx_ff[IDX_W-1:0];
      first_idx_ff <= first_idx_in;
      first_ent_ff <= first_ent_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.action         = rsp_ff.action;
   assign rsp_if.entry_index    = rsp_ff.entry_index;
   assign rsp_if.entry_cost     = rsp_ff.entry_cost;
   assign rsp_if.entry_next_hop = rsp_ff.entry_next_hop;
   assign rsp_if.entry_iface    = rsp_ff.entry_iface;
   assign rsp_if.table_count    = rsp_ff.table_count;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count above table depth");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN) && done)
      else $error("table written outside the end of a search");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN) && !found_ff && !pend_ff)
      else $error("accepted transaction did not start a clean search");

   a_dropped_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.action == ACT_DROPPED)) |-> (count_ff == CNT_W'(TABLE_DEPTH)))
      else $error("route dropped while table not full");

endmodule
`default_nettype wire
